// File: rtl/core/vas_pkg.sv
// Shared types and constants of the valve actuator supervisor.
package vas_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned TMR_W    = 8;
  localparam int unsigned SECS_W   = 16;
  localparam int unsigned FLT_W    = 4;
  localparam int unsigned LAMP_W   = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE       = 3'd0,
    CMD_AUTO_OPEN  = 3'd1,
    CMD_AUTO_CLOSE = 3'd2,
    CMD_KEY_OPEN   = 3'd3,
    CMD_KEY_CLOSE  = 3'd4,
    CMD_ACK        = 3'd5
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHECK_EN   = 2'd0,
    REG_REMOTE     = 2'd1,
    REG_PRESS_TMO  = 2'd2,
    REG_LIMIT_TMO  = 2'd3
  } reg_idx_t;

  // Fault and check-enable bit positions.
  localparam int unsigned FLT_PRESS = 0;
  localparam int unsigned FLT_LIMIT = 1;
  localparam int unsigned FLT_THERM = 2;
  localparam int unsigned FLT_ALARM = 3;

  localparam logic [LAMP_W-1:0] LAMP_OPEN   = 8'hf0;
  localparam logic [LAMP_W-1:0] LAMP_CLOSED = 8'h0f;
  localparam logic [LAMP_W-1:0] LAMP_LOCAL_MASK = 8'h11;
  localparam logic [LAMP_W-1:0] LAMP_FAULT  = 8'hf5;

  localparam logic [TMR_W-1:0] PRESS_TMO_RST = 8'd10;
  localparam logic [TMR_W-1:0] LIMIT_TMO_RST = 8'd5;
  localparam logic [SECS_W-1:0] SECS_MAX = 16'hffff;

endpackage

// File: rtl/core/vas_in_if.sv
// Request channel of the valve actuator supervisor: one control step per request.
interface vas_in_if
  import vas_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic             second_tick;
  logic             pressure_ok;
  logic             limit_switch;
  logic             thermal_trip;
  logic             alarm_input;

  modport source (output valid, command, second_tick, pressure_ok, limit_switch,
                  thermal_trip, alarm_input, input ready);
  modport sink   (input valid, command, second_tick, pressure_ok, limit_switch,
                  thermal_trip, alarm_input, output ready);
endinterface

// File: rtl/core/vas_out_if.sv
// Result channel of the valve actuator supervisor: one status word per request.
interface vas_out_if
  import vas_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              drive_on;
  logic [LAMP_W-1:0] lamp_pattern;
  logic              is_open;
  logic [FLT_W-1:0]  fault_flags;
  logic              operator_mode;
  logic [SECS_W-1:0] seconds_in_state;

  modport source (output valid, drive_on, lamp_pattern, is_open, fault_flags,
                  operator_mode, seconds_in_state, input ready);
  modport sink   (input valid, drive_on, lamp_pattern, is_open, fault_flags,
                  operator_mode, seconds_in_state, output ready);
endinterface

// File: rtl/core/valve_actuator_supervisor.sv
// Valve actuator supervisor top level: state update, feedback checks and result register.
// Result: a request accepted at one clock edge has its result valid from that edge on,
//   so the result can be taken in the cycle after the request.
// Throughput: one request per cycle while results are taken; the whole control step is one
//   pass of logic into the state and result registers, and a waiting result is replaced as it is taken.
// Reset (rst_n low, synchronous): valve closed, no faults, timers loaded with 10 and 5
//   seconds, all checks disabled, local mode, no result pending.
module valve_actuator_supervisor
  import vas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  vas_in_if.sink                in_req,
  vas_out_if.source             out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [FLT_W-1:0]  check_en_r;
  logic              remote_r;
  logic [TMR_W-1:0]  press_tmo_r;
  logic [TMR_W-1:0]  limit_tmo_r;

  // Control state carried from one request to the next.
  logic              open_r,     open_nxt;
  logic              held_r,     held_nxt;
  logic              opflag_r,   opflag_nxt;
  logic [FLT_W-1:0]  faults_r,   faults_nxt;
  logic [TMR_W-1:0]  press_tmr_r, press_tmr_nxt;
  logic [TMR_W-1:0]  limit_tmr_r, limit_tmr_nxt;
  logic [SECS_W-1:0] secs_r,     secs_nxt;
  logic [LAMP_W-1:0] lamp_nxt;

  // Result register.
  logic              out_valid_r;
  logic              drive_r;
  logic [LAMP_W-1:0] lamp_r;
  logic [FLT_W-1:0]  flags_r;
  logic              opmode_r;
  logic [SECS_W-1:0] out_secs_r;

  logic              in_fire;

  // A new request is taken whenever the result register is empty or is being emptied.
  assign in_req.ready = !out_valid_r || out_res.ready;
  assign in_fire      = in_req.valid && in_req.ready;

  // The user must write configuration only while no request is in flight; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_en_r  <= '0;
      remote_r    <= 1'b0;
      press_tmo_r <= PRESS_TMO_RST;
      limit_tmo_r <= LIMIT_TMO_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CHECK_EN:  check_en_r  <= cfg_wdata[FLT_W-1:0];
        REG_REMOTE:    remote_r    <= cfg_wdata[0];
        REG_PRESS_TMO: press_tmo_r <= cfg_wdata[TMR_W-1:0];
        REG_LIMIT_TMO: limit_tmo_r <= cfg_wdata[TMR_W-1:0];
        default: ;
      endcase
    end
  end

  // One control step. The acknowledge clears faults first, so a condition
  // that still holds latches its fault again in the same step.
  always_comb begin
    held_nxt   = held_r;
    opflag_nxt = opflag_r;
    faults_nxt = faults_r;

    case (cmd_t'(in_req.command))
      CMD_AUTO_OPEN:  if (!open_r) held_nxt = 1'b1;
      CMD_AUTO_CLOSE: if (!remote_r && !opflag_r && open_r) held_nxt = 1'b0;
      CMD_KEY_OPEN: begin
        if (!remote_r) begin
          held_nxt   = 1'b1;
          opflag_nxt = 1'b1;
        end
      end
      CMD_KEY_CLOSE: begin
        if (!remote_r) begin
          held_nxt   = 1'b0;
          opflag_nxt = 1'b0;
        end
      end
      CMD_ACK: faults_nxt = '0;
      default: ;
    endcase

    // The tick is counted before a state change clears the count.
    secs_nxt = secs_r;
    if (in_req.second_tick && secs_r != SECS_MAX) secs_nxt = secs_r + 1'b1;

    // Any latched fault forces the valve closed.
    if (|faults_nxt) held_nxt = 1'b0;

    open_nxt = open_r;
    if (held_nxt != open_r) begin
      open_nxt = held_nxt;
      secs_nxt = '0;
    end

    // Pressure feedback must follow the new state within its timeout.
    press_tmr_nxt = press_tmr_r;
    if (check_en_r[FLT_PRESS]) begin
      if (open_nxt == in_req.pressure_ok) press_tmr_nxt = press_tmo_r;
      if (in_req.second_tick && press_tmr_nxt != '0) press_tmr_nxt = press_tmr_nxt - 1'b1;
      if (press_tmr_nxt == '0) faults_nxt[FLT_PRESS] = 1'b1;
    end

    // The limit switch is supervised only while open.
    limit_tmr_nxt = limit_tmr_r;
    if (check_en_r[FLT_LIMIT]) begin
      if (!open_nxt || in_req.limit_switch) limit_tmr_nxt = limit_tmo_r;
      if (in_req.second_tick && limit_tmr_nxt != '0) limit_tmr_nxt = limit_tmr_nxt - 1'b1;
      if (limit_tmr_nxt == '0) faults_nxt[FLT_LIMIT] = 1'b1;
    end

    if (check_en_r[FLT_THERM] && in_req.thermal_trip) faults_nxt[FLT_THERM] = 1'b1;
    if (check_en_r[FLT_ALARM] && in_req.alarm_input)  faults_nxt[FLT_ALARM] = 1'b1;

    // Lamp: open or closed pattern, dimmed in remote or operator mode, fault overrides.
    lamp_nxt = open_nxt ? LAMP_OPEN : LAMP_CLOSED;
    if (remote_r || opflag_nxt) lamp_nxt = lamp_nxt & ~LAMP_LOCAL_MASK;
    if (|faults_nxt) lamp_nxt = LAMP_FAULT;
  end

  // Control state advances only on an accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= 1'b0;
      held_r      <= 1'b0;
      opflag_r    <= 1'b0;
      faults_r    <= '0;
      press_tmr_r <= PRESS_TMO_RST;
      limit_tmr_r <= LIMIT_TMO_RST;
      secs_r      <= '0;
    end else if (in_fire) begin
      open_r      <= open_nxt;
      held_r      <= held_nxt;
      opflag_r    <= opflag_nxt;
      faults_r    <= faults_nxt;
      press_tmr_r <= press_tmr_nxt;
      limit_tmr_r <= limit_tmr_nxt;
      secs_r      <= secs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      drive_r    <= open_nxt;
      lamp_r     <= lamp_nxt;
      flags_r    <= faults_nxt;
      opmode_r   <= opflag_nxt;
      out_secs_r <= secs_nxt;
    end
  end

  assign out_res.valid            = out_valid_r;
  assign out_res.drive_on         = drive_r;
  assign out_res.is_open          = drive_r;
  assign out_res.lamp_pattern     = lamp_r;
  assign out_res.fault_flags      = flags_r;
  assign out_res.operator_mode    = opmode_r;
  assign out_res.seconds_in_state = out_secs_r;

  // A fault latched by an earlier request and not acknowledged closes the valve.
  a_fault_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (faults_r != '0) && (in_req.command != CMD_ACK) |=> !drive_r)
    else $error("drive open while an earlier fault is latched");

  // A latched fault always shows the fault lamp.
  a_fault_lamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (flags_r != '0) |-> lamp_r == LAMP_FAULT)
    else $error("fault latched without fault lamp");

  // An accepted request always leaves a result behind.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted request produced no result");

  // A change of valve state restarts the seconds count.
  a_secs_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (open_nxt != open_r) |=> out_secs_r == '0)
    else $error("seconds count not cleared on state change");

endmodule
